// ===== hw/rtl/swo_pkg.sv =====
// shared constants for the shortest or-window block
package swo_pkg;

  // width of the threshold register, fixed by the register map
  localparam int THRESH_BITS = 30;

endpackage

// ===== hw/rtl/swo_if.sv =====
// valid/ready channel interfaces for the shortest or-window block

interface swo_in_if #(
  parameter int VALUE_BITS = 30
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink (input valid, input value, input last_item, output ready);
endinterface

interface swo_out_if #(
  parameter int LEN_BITS = 11
);
  logic                valid;
  logic                ready;
  logic [LEN_BITS-1:0] best_length;
  logic                found;
  logic                window_overflow;
  logic                array_done;

  modport source (output valid, output best_length, output found, output window_overflow,
                  output array_done, input ready);
  modport sink (input valid, input best_length, input found, input window_overflow,
                input array_done, output ready);
endinterface

interface swo_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [swo_pkg::THRESH_BITS-1:0] or_threshold;

  modport source (output valid, output or_threshold, input ready);
  modport sink (input valid, input or_threshold, output ready);
endinterface

// ===== hw/rtl/shortest_window_or_at_least.sv =====
// top level: shortest window whose bitwise or reaches a threshold
//
//   channel  dir   payload                                           handshake
//   item     in    value, last_item                                  valid/ready
//   result   out   best_length, found, window_overflow, array_done  valid/ready
//   cfg      in    or_threshold                                      valid/ready
//
// steps: each word takes an accept step and a check step, plus a pop step
//   for every element popped off the front (ram read, then counter update);
//   a full store adds an append step for the read of the pushed-out element.
// reset: control state and bit counters clear at once; the window ram is
//   never cleared, only entries written since the array began are read.
// stalls: the result sits in an output register, so the next item word is
//   taken while it waits; the block holds in its check step only when a new
//   result is ready and the previous one has not been taken yet.
module shortest_window_or_at_least #(
  parameter int WINDOW_DEPTH = 1024,
  parameter int VALUE_BITS   = 30
) (
  input  logic            clk,
  input  logic            rst,
  swo_in_if.sink          item,
  swo_out_if.source       result,
  swo_cfg_if.sink         cfg
);

  localparam int IDX_BITS = $clog2(WINDOW_DEPTH);
  localparam int LEN_BITS = $clog2(WINDOW_DEPTH + 1);
  localparam int CMP_BITS = (VALUE_BITS > swo_pkg::THRESH_BITS) ? VALUE_BITS
                                                                : swo_pkg::THRESH_BITS;

  typedef enum logic [1:0] {
    S_IDLE,    // waiting for an item word
    S_APPEND,  // store was full: drop oldest and append in one step
    S_CHECK,   // test window or against threshold
    S_POP      // ram word of the oldest element is back, remove it
  } state_t;

  state_t state;

  // threshold register
  logic [swo_pkg::THRESH_BITS-1:0] threshold;

  // window bookkeeping
  logic [IDX_BITS-1:0]   head;
  logic [IDX_BITS-1:0]   tail;
  logic [LEN_BITS-1:0]   length;
  logic [LEN_BITS-1:0]   shortest;
  logic                  any_found;
  logic                  overflow_seen;
  logic [LEN_BITS-1:0]   bit_count [VALUE_BITS];

  // item held across the full-store step
  logic [VALUE_BITS-1:0] value_q;
  logic                  last_q;

  // output register
  logic                  out_valid;
  logic [LEN_BITS-1:0]   out_best;
  logic                  out_found;
  logic                  out_overflow;
  logic                  out_done;

  // ram ports
  logic                  ram_we;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic [VALUE_BITS-1:0] ram_rdata;

  logic                  item_acc;
  logic                  store_full;
  logic                  out_free;
  logic                  qualify;
  logic                  stream_clear;
  logic [VALUE_BITS-1:0] win_or;
  logic [VALUE_BITS-1:0] add_vec;
  logic [VALUE_BITS-1:0] sub_vec;
  logic [IDX_BITS-1:0]   head_inc;
  logic [IDX_BITS-1:0]   tail_inc;

  // ---------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------
  assign item.ready   = (state == S_IDLE);
  assign item_acc     = item.valid && item.ready;
  assign cfg.ready    = 1'b1;

  assign result.valid           = out_valid;
  assign result.best_length     = out_best;
  assign result.found           = out_found;
  assign result.window_overflow = out_overflow;
  assign result.array_done      = out_done;

  assign out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg.valid && cfg.ready) begin
      threshold <= cfg.or_threshold;
    end
  end

  // ---------------------------------------------------------------------
  // window or and threshold test
  // ---------------------------------------------------------------------
  always_comb begin
    for (int b = 0; b < VALUE_BITS; b++) begin
      win_or[b] = (bit_count[b] != '0);
    end
  end

  assign qualify = (length != '0) &&
                   (CMP_BITS'(win_or) >= CMP_BITS'(threshold));

  assign store_full = (length == LEN_BITS'(WINDOW_DEPTH));

  // circular index step
  assign head_inc = (head == IDX_BITS'(WINDOW_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == IDX_BITS'(WINDOW_DEPTH - 1)) ? '0 : tail + 1'b1;

  // ---------------------------------------------------------------------
  // window store: written at tail, always read at head
  // ---------------------------------------------------------------------
  assign ram_we    = (item_acc && !store_full) || (state == S_APPEND);
  assign ram_wdata = (state == S_APPEND) ? value_q : item.value;

  swo_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (WINDOW_DEPTH)
  ) u_window_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (ram_wdata),
    .raddr (head),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // per-bit counters: add the appended word, subtract the word read back
  // ---------------------------------------------------------------------
  assign add_vec = ram_we ? ram_wdata : '0;
  assign sub_vec = ((state == S_APPEND) || (state == S_POP)) ? ram_rdata : '0;

  // end of array: result goes out and all stream state returns to reset
  assign stream_clear = (state == S_CHECK) && !qualify && out_free && last_q;

  always_ff @(posedge clk) begin
    if (rst || stream_clear) begin
      for (int b = 0; b < VALUE_BITS; b++) begin
        bit_count[b] <= '0;
      end
    end else begin
      for (int b = 0; b < VALUE_BITS; b++) begin
        bit_count[b] <= bit_count[b] + LEN_BITS'(add_vec[b])
                        - LEN_BITS'(sub_vec[b] && (bit_count[b] != '0));
      end
    end
  end

  // ---------------------------------------------------------------------
  // sequencer and output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head          <= '0;
      tail          <= '0;
      length        <= '0;
      shortest      <= '0;
      any_found     <= 1'b0;
      overflow_seen <= 1'b0;
      last_q        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_acc) begin
            last_q <= item.last_item;
            if (store_full) begin
              // oldest word is being read this cycle, append next cycle
              value_q <= item.value;
              state   <= S_APPEND;
            end else begin
              tail   <= tail_inc;
              length <= length + 1'b1;
              state  <= S_CHECK;
            end
          end
        end
        S_APPEND: begin
          // drop one and add one: length stays at full
          head          <= head_inc;
          tail          <= tail_inc;
          overflow_seen <= 1'b1;
          state         <= S_CHECK;
        end
        S_CHECK: begin
          if (qualify) begin
            if (!any_found || (length < shortest)) begin
              shortest <= length;
            end
            any_found <= 1'b1;
            state     <= S_POP;
          end else if (out_free) begin
            out_valid    <= 1'b1;
            out_best     <= any_found ? shortest : '0;
            out_found    <= any_found;
            out_overflow <= overflow_seen;
            out_done     <= last_q;
            if (last_q) begin
              head          <= '0;
              tail          <= '0;
              length        <= '0;
              shortest      <= '0;
              any_found     <= 1'b0;
              overflow_seen <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        S_POP: begin
          head   <= head_inc;
          length <= length - 1'b1;
          state  <= S_CHECK;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    length <= LEN_BITS'(WINDOW_DEPTH))
    else $error("window length beyond store depth");

  a_empty_indices: assert property (@(posedge clk) disable iff (rst)
    (length == '0) |-> (head == tail))
    else $error("empty window with head and tail apart");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |=> (length == $past(length) - 1'b1))
    else $error("pop did not shorten the window");

  a_found_length: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_found == (out_best != '0)))
    else $error("found flag disagrees with best length");

  a_accept_step: assert property (@(posedge clk) disable iff (rst)
    item_acc |=> ((state == S_APPEND) || (state == S_CHECK)))
    else $error("accepted word not processed");

endmodule

// ===== hw/rtl/swo_ram.sv =====
// generic single-write, single-read ram with registered read data
module swo_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read during write to the same address returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/shortest_window_or_at_least_test.sv =====
// self-checking testbench for the shortest or-window block
module shortest_window_or_at_least_test;

  localparam int VALUE_BITS   = 30;
  localparam int LEN_BITS     = 11;
  localparam int WINDOW_DEPTH = 1024;
  // a single word can pop every element of a full window
  localparam int STALL_LIMIT  = 12000;
  localparam logic [VALUE_BITS-1:0] ALL_ONES = '1;

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic                  last_item;
  } item_word_t;

  typedef struct packed {
    logic [LEN_BITS-1:0] best_length;
    logic                found;
    logic                window_overflow;
    logic                array_done;
  } window_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  swo_in_if  #(.VALUE_BITS(VALUE_BITS)) item_ch ();
  swo_out_if #(.LEN_BITS(LEN_BITS))     result_ch ();
  swo_cfg_if                            cfg_ch ();

  shortest_window_or_at_least #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch),
    .cfg(cfg_ch)
  );

  always #10 clk = ~clk;

  // words waiting to be sent, and the results the window should produce
  item_word_t     queued_words[$];
  window_result_t pending_results[$];

  int unsigned words_queued = 0;
  int unsigned results_seen = 0;
  int unsigned errors       = 0;
  bit          idling       = 1'b0;
  logic        item_taken   = 1'b0;

  // shadow of the block: circular window, per-bit population counts
  logic [VALUE_BITS-1:0] window_vals [WINDOW_DEPTH];
  int unsigned           bit_pop [VALUE_BITS];
  int unsigned           head_slot  = 0;
  int unsigned           tail_slot  = 0;
  int unsigned           window_len = 0;
  int unsigned           shortest   = 0;
  bit                    any_found  = 1'b0;
  bit                    overflowed = 1'b0;
  logic [swo_pkg::THRESH_BITS-1:0] threshold = '0;

  initial begin
    foreach (bit_pop[b]) bit_pop[b] = 0;
  end

  // oldest element leaves: its set bits come off the counters
  function automatic void drop_oldest();
    for (int b = 0; b < VALUE_BITS; b++) begin
      if (window_vals[head_slot][b] && bit_pop[b] > 0) begin
        bit_pop[b]--;
      end
    end
    head_slot  = (head_slot + 1) % WINDOW_DEPTH;
    window_len = window_len - 1;
  endfunction

  // append one element, shrink from the front while the or still qualifies
  function automatic window_result_t fold_into_window(input item_word_t w);
    window_result_t        r;
    logic [VALUE_BITS-1:0] acc;
    if (window_len >= WINDOW_DEPTH) begin
      drop_oldest();
      overflowed = 1'b1;
    end
    window_vals[tail_slot] = w.value;
    tail_slot  = (tail_slot + 1) % WINDOW_DEPTH;
    window_len = window_len + 1;
    for (int b = 0; b < VALUE_BITS; b++) begin
      if (w.value[b]) begin
        bit_pop[b]++;
      end
    end
    while (window_len > 0) begin
      acc = '0;
      for (int b = 0; b < VALUE_BITS; b++) begin
        acc[b] = (bit_pop[b] > 0);
      end
      // an empty window never gets here, so a zero threshold still needs one element
      if (acc < threshold) break;
      if (!any_found || window_len < shortest) begin
        shortest = window_len;
      end
      any_found = 1'b1;
      drop_oldest();
    end
    r.best_length     = any_found ? LEN_BITS'(shortest) : '0;
    r.found           = any_found;
    r.window_overflow = overflowed;
    r.array_done      = w.last_item;
    // end of array: stream state back to reset, threshold kept
    if (w.last_item) begin
      foreach (bit_pop[b]) bit_pop[b] = 0;
      head_slot  = 0;
      tail_slot  = 0;
      window_len = 0;
      shortest   = 0;
      any_found  = 1'b0;
      overflowed = 1'b0;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // driver: a word stays on the channel until taken; gaps only between words
  int unsigned send_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || item_taken) begin
      if (send_gap > 0 && idling) begin
        item_ch.valid <= 1'b0;
        send_gap--;
      end else if (queued_words.size() > 0) begin
        item_word_t w;
        w = queued_words.pop_front();
        item_ch.valid     <= 1'b1;
        item_ch.value     <= w.value;
        item_ch.last_item <= w.last_item;
        send_gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // result side back-pressure in bursts
  int unsigned take_gap = 0;
  always @(negedge clk) begin
    if (take_gap > 0 && idling) begin
      result_ch.ready <= 1'b0;
      take_gap--;
    end else begin
      result_ch.ready <= 1'b1;
      take_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : 0;
    end
  end

  // monitor: predict on every accepted word, then check every accepted result
  always @(posedge clk) begin
    item_word_t     w;
    window_result_t want;
    item_taken <= !rst && item_ch.valid && item_ch.ready;
    if (!rst && item_ch.valid && item_ch.ready) begin
      w.value     = item_ch.value;
      w.last_item = item_ch.last_item;
      pending_results.push_back(fold_into_window(w));
    end
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation pending");
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("best_length", want.best_length, result_ch.best_length);
        check_field("found", want.found, result_ch.found);
        check_field("window_overflow", want.window_overflow, result_ch.window_overflow);
        check_field("array_done", want.array_done, result_ch.array_done);
        results_seen++;
      end
    end
  end

  // watchdog: too long without any handshake means the block is hung
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_word(input logic [VALUE_BITS-1:0] v, input logic last_flag);
    item_word_t w;
    w.value     = v;
    w.last_item = last_flag;
    queued_words.push_back(w);
    words_queued++;
  endtask

  // register write, only issued with the block drained
  task automatic write_threshold(input logic [swo_pkg::THRESH_BITS-1:0] t);
    @(negedge clk);
    cfg_ch.valid        = 1'b1;
    cfg_ch.or_threshold = t;
    do @(posedge clk); while (!cfg_ch.ready);
    threshold = t;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // hold the sender until every result is back, then wait out the clearing
  // after a last word
  task automatic settle();
    while (results_seen != words_queued) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // element mix: random, sparse single bits, zeros, all ones
  function automatic logic [VALUE_BITS-1:0] pick_value(input logic [VALUE_BITS-1:0] mask);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return VALUE_BITS'($urandom) & mask;
      4, 5, 6:    return (VALUE_BITS'(1) << $urandom_range(0, VALUE_BITS - 1)) & mask;
      7:          return '0;
      8:          return ALL_ONES & mask;
      default:    return VALUE_BITS'($urandom) & VALUE_BITS'($urandom) & mask;
    endcase
  endfunction

  // fill arrays of mostly short length with random content
  task automatic queue_arrays(input int unsigned count);
    int unsigned n;
    int unsigned len;
    n = 0;
    while (n < count) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      for (int i = 0; i < len; i++) begin
        queue_word(pick_value(ALL_ONES), i == len - 1);
      end
      n += len;
    end
  endtask

  initial begin
    logic [swo_pkg::THRESH_BITS-1:0] t;
    item_ch.valid        = 1'b0;
    item_ch.value        = '0;
    item_ch.last_item    = 1'b0;
    result_ch.ready      = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.or_threshold  = '0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // zero threshold: every element alone qualifies, zero value included
    write_threshold('0);
    queue_word('0, 1'b0);
    queue_word(ALL_ONES, 1'b0);
    queue_word(30'h1555_5555, 1'b1);
    settle();

    // full threshold: empty-result array, two halves pairing, single word
    write_threshold(ALL_ONES);
    queue_word('0, 1'b0);
    queue_word('0, 1'b1);
    queue_word(30'h1555_5555, 1'b0);
    queue_word(30'h2AAA_AAAA, 1'b0);
    queue_word(ALL_ONES, 1'b0);
    queue_word(30'h0000_0001, 1'b1);
    settle();

    // small threshold: shortest stays while longer windows qualify, then a
    // fresh array after the last word starts with nothing found
    write_threshold(30'd5);
    queue_word(30'd4, 1'b0);
    queue_word(30'd1, 1'b0);
    queue_word(30'd2, 1'b0);
    queue_word(30'd8, 1'b1);
    queue_word(30'd1, 1'b0);
    queue_word(30'd4, 1'b1);
    settle();

    // store full: top bit never present until the last word, so the window
    // fills, overflows, then the last word collapses it in one go
    idling = 1'b1;
    write_threshold(30'h2000_0000 | swo_pkg::THRESH_BITS'($urandom_range(0, 255)));
    for (int i = 0; i < WINDOW_DEPTH + 60; i++) begin
      queue_word(pick_value(30'h1FFF_FFFF), 1'b0);
    end
    queue_word(ALL_ONES, 1'b1);
    // a second array right after must see the overflow flag cleared
    queue_word(ALL_ONES, 1'b1);
    settle();

    // random phases over a spread of thresholds, some with no idling at all
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0:       t = '0;
        1:       t = ALL_ONES;
        2:       t = swo_pkg::THRESH_BITS'(1) << $urandom_range(0, swo_pkg::THRESH_BITS - 1);
        3:       t = swo_pkg::THRESH_BITS'($urandom_range(1, 4095));
        4:       t = swo_pkg::THRESH_BITS'($urandom) | 30'h3000_0000;
        default: t = swo_pkg::THRESH_BITS'($urandom);
      endcase
      idling = (phase % 3 != 2);
      write_threshold(t);
      queue_arrays(130);
      settle();
    end

    // last stretch runs without any idling on either side
    idling = 1'b0;
    write_threshold(swo_pkg::THRESH_BITS'($urandom));
    queue_arrays(150);
    settle();
    repeat (20) @(negedge clk);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
